// ===== hw/rtl/iou_pkg.sv =====
`default_nettype none
package iou_pkg;

   typedef enum logic [2:0] {
      KIND_MATCHED = 3'd0,
      KIND_NEW     = 3'd1,
      KIND_DROPPED = 3'd2,
      KIND_REPORT  = 3'd3,
      KIND_EMPTY   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CSR_NUMERATOR   = 2'd0,
      CSR_DENOMINATOR = 2'd1,
      CSR_INIT_LIFE   = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_TEST,
      ST_DECIDE,
      ST_AGE,
      ST_PICK,
      ST_EMIT,
      ST_OUT
   } state_type;

   localparam int unsigned ID_BITS   = 32;
   localparam int unsigned LIFE_BITS = 4;
   localparam int unsigned MAX_RESULTS = 16;

endpackage
`default_nettype wire

// ===== hw/rtl/iou_overlap.sv =====
`default_nettype none
// combinational rectangle overlap geometry: intersection width and height
module iou_overlap #(
   parameter int unsigned COORD_BITS = 12
) (
   input  wire logic [COORD_BITS-1:0]   ax,
   input  wire logic [COORD_BITS-1:0]   ay,
   input  wire logic [COORD_BITS-1:0]   aw,
   input  wire logic [COORD_BITS-1:0]   ah,
   input  wire logic [COORD_BITS-1:0]   bx,
   input  wire logic [COORD_BITS-1:0]   by,
   input  wire logic [COORD_BITS-1:0]   bw,
   input  wire logic [COORD_BITS-1:0]   bh,
   output logic      [COORD_BITS:0]     iw,
   output logic      [COORD_BITS:0]     ih
);
   logic [COORD_BITS:0] x1, y1, x2, y2, ax2, bx2, ay2, by2;

   always_comb begin
      x1  = (ax > bx) ? {1'b0, ax} : {1'b0, bx};
      y1  = (ay > by) ? {1'b0, ay} : {1'b0, by};
      ax2 = {1'b0, ax} + {1'b0, aw};
      bx2 = {1'b0, bx} + {1'b0, bw};
      ay2 = {1'b0, ay} + {1'b0, ah};
      by2 = {1'b0, by} + {1'b0, bh};
      x2  = (ax2 < bx2) ? ax2 : bx2;
      y2  = (ay2 < by2) ? ay2 : by2;
      iw  = (x2 > x1) ? x2 - x1 : '0;
      ih  = (y2 > y1) ? y2 - y1 : '0;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/iou_region_tracker.sv =====
`default_nettype none
// region tracker: keeps a table of tracked rectangles matched by intersection
// over union against incoming detected regions
// req channel carries one item per region or one end-of-frame item
// rsp channel returns one item per region (matched, new, dropped) and, per end
// of frame, one report item per surviving track, at most MAX_RESULTS, in
// ascending id order, or one no-tracks item; tlast marks each request's last item
// a region walks every table slot in turn through one shared overlap unit and
// one shared multiplier: a live slot passes the scan, mul1, mul2, mul3 and test
// states, a free slot only the scan state; then decide and out emit the result
// an end of frame ages every slot in the age state, then per reported track
// searches all slots for the lowest unreported id and hands it over in emit
// req_tready is high only when idle; one request is in flight at a time
// a stalled receiver holds the rsp register and the sequencer waits before
// loading the next result item
// reset clears the valid, found and done bits and the id counter and loads the
// csr defaults; rectangle, id and life stores are written before they are read
// csr writes are taken on any cycle and must only occur while idle
module iou_region_tracker #(
   parameter int unsigned MAX_TRACKS = 16,
   parameter int unsigned COORD_BITS = 12
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // action, region_x, region_y, region_w, region_h (zero filled to bytes)
   input  wire logic [((1+4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // kind, track_id, track_x, track_y, track_w, track_h, life_left
   output logic [((3+32+4*COORD_BITS+4+7)/8)*8-1:0] rsp_tdata,
   output logic                          rsp_tlast,
   input  wire logic                     csr_we,
   input  wire logic [1:0]               csr_index,
   input  wire logic [7:0]               csr_wdata
);
   localparam int unsigned SB = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int unsigned CB = COORD_BITS;
   localparam int unsigned RB = 4 * CB;
   localparam int unsigned AB = 2 * CB + 2;   // area width
   localparam int unsigned MB = CB + 1;       // narrow multiplier operand width
   localparam int unsigned PB = AB + 8;       // product width
   localparam int unsigned IW = ((1 + RB + 7) / 8) * 8;
   localparam int unsigned OD = 3 + 32 + RB + 4;
   localparam int unsigned OW = ((OD + 7) / 8) * 8;
   localparam int unsigned KB = $clog2(iou_pkg::MAX_RESULTS + 1);

   // configuration
   logic [7:0] num_ff, den_ff;
   logic [3:0] init_life_ff;

   // track table
   logic [MAX_TRACKS-1:0] valid_ff, valid_in, found_ff, found_in, done_ff, done_in;
   logic [31:0]   id_mem   [MAX_TRACKS];
   logic [RB-1:0] rect_mem [MAX_TRACKS];
   logic [3:0]    life_mem [MAX_TRACKS];
   logic [31:0]   next_id_ff, next_id_in;

   // sequencer
   iou_pkg::state_type state_ff, state_in;
   logic [SB-1:0] slot_ff, slot_in;
   logic          slot_end;
   logic [RB-1:0] reg_ff, reg_in;
   logic          best_ok_ff, best_ok_in, free_ok_ff, free_ok_in;
   logic [SB-1:0] best_ff, best_in, free_ff, free_in;
   logic [31:0]   best_id_ff, best_id_in;
   logic          pick_ok_ff, pick_ok_in;
   logic [SB-1:0] pick_ff, pick_in;
   logic [31:0]   pick_id_ff, pick_id_in;
   logic [KB-1:0] count_ff, count_in;
   logic [AB-1:0] inter_ff, area_ff, uni_ff;
   logic [PB-1:0] rhs_ff;
   logic [AB-1:0] mul_a;
   logic [MB-1:0] mul_b;
   logic [PB-1:0] mul_p;
   logic [CB:0]   iw_w, ih_w;

   // output register
   logic          ovalid_ff, ovalid_in, olast_ff, olast_in;
   logic [OD-1:0] odata_ff, odata_in;

   logic [CB-1:0] rx, ry, rw, rh, tx, ty, tw, th;
   logic [31:0]   slot_id;
   logic [RB-1:0] slot_rect;
   logic [3:0]    slot_life;
   logic [3:0]    aged_life;
   logic          wr_match, wr_new, wr_age, was_empty, report_last;

   assign rx = reg_ff[CB-1:0];
   assign ry = reg_ff[2*CB-1:CB];
   assign rw = reg_ff[3*CB-1:2*CB];
   assign rh = reg_ff[4*CB-1:3*CB];
   assign slot_id   = id_mem[slot_ff];
   assign slot_rect = rect_mem[slot_ff];
   assign slot_life = life_mem[slot_ff];
   assign tx = slot_rect[CB-1:0];
   assign ty = slot_rect[2*CB-1:CB];
   assign tw = slot_rect[3*CB-1:2*CB];
   assign th = slot_rect[4*CB-1:3*CB];
   assign slot_end = (slot_ff == SB'(MAX_TRACKS - 1));

   // last report when no further unreported survivor or result cap hit
   assign was_empty   = ((valid_ff & ~done_ff & ~(MAX_TRACKS'(1) << pick_ff)) == '0);
   assign report_last = was_empty || (count_ff == KB'(iou_pkg::MAX_RESULTS - 1));

   iou_overlap #(.COORD_BITS(CB)) u_overlap (
      .ax(rx), .ay(ry), .aw(rw), .ah(rh),
      .bx(tx), .by(ty), .bw(tw), .bh(th),
      .iw(iw_w), .ih(ih_w)
   );

   // shared multiplier, operands chosen by state
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         iou_pkg::ST_SCAN: begin
            mul_a = AB'(iw_w);
            mul_b = ih_w;
         end
         iou_pkg::ST_MUL1: begin
            mul_a = AB'(rw);
            mul_b = MB'(rh);
         end
         iou_pkg::ST_MUL2: begin
            mul_a = AB'(tw);
            mul_b = MB'(th);
         end
         iou_pkg::ST_MUL3: begin
            mul_a = uni_ff;
            mul_b = MB'(num_ff);
         end
         iou_pkg::ST_TEST: begin
            mul_a = inter_ff;
            mul_b = MB'(den_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = PB'(mul_a) * PB'(mul_b);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iou_pkg::ST_IDLE:
            if (req_tvalid && req_tready)
               state_in = req_tdata[0] ? iou_pkg::ST_AGE : iou_pkg::ST_SCAN;
         iou_pkg::ST_SCAN:
            if (valid_ff[slot_ff]) state_in = iou_pkg::ST_MUL1;
            else if (slot_end) state_in = iou_pkg::ST_DECIDE;
         iou_pkg::ST_MUL1: state_in = iou_pkg::ST_MUL2;
         iou_pkg::ST_MUL2: state_in = iou_pkg::ST_MUL3;
         iou_pkg::ST_MUL3: state_in = iou_pkg::ST_TEST;
         iou_pkg::ST_TEST:
            state_in = slot_end ? iou_pkg::ST_DECIDE : iou_pkg::ST_SCAN;
         iou_pkg::ST_DECIDE:
            if (!ovalid_ff || rsp_tready) state_in = iou_pkg::ST_OUT;
         iou_pkg::ST_AGE:
            if (slot_end) state_in = iou_pkg::ST_PICK;
         iou_pkg::ST_PICK:
            if (slot_end) state_in = iou_pkg::ST_EMIT;
         iou_pkg::ST_EMIT:
            if (!ovalid_ff || rsp_tready) begin
               if (!pick_ok_ff)
                  state_in = (count_ff == '0) ? iou_pkg::ST_OUT : iou_pkg::ST_IDLE;
               else if (report_last) state_in = iou_pkg::ST_IDLE;
               else state_in = iou_pkg::ST_PICK;
            end
         iou_pkg::ST_OUT:
            if (!ovalid_ff || rsp_tready) state_in = iou_pkg::ST_IDLE;
         default: state_in = iou_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      slot_in    = slot_ff;
      reg_in     = reg_ff;
      best_ok_in = best_ok_ff;
      best_in    = best_ff;
      best_id_in = best_id_ff;
      free_ok_in = free_ok_ff;
      free_in    = free_ff;
      pick_ok_in = pick_ok_ff;
      pick_in    = pick_ff;
      pick_id_in = pick_id_ff;
      count_in   = count_ff;
      valid_in   = valid_ff;
      found_in   = found_ff;
      done_in    = done_ff;
      next_id_in = next_id_ff;
      ovalid_in  = ovalid_ff && !rsp_tready;
      olast_in   = olast_ff;
      odata_in   = odata_ff;
      wr_match   = 1'b0;
      wr_new     = 1'b0;
      wr_age     = 1'b0;
      aged_life  = slot_life;
      req_tready = (state_ff == iou_pkg::ST_IDLE);
      case (state_ff)
         iou_pkg::ST_IDLE:
            if (req_tvalid) begin
               reg_in     = req_tdata[RB:1];
               slot_in    = '0;
               best_ok_in = 1'b0;
               free_ok_in = 1'b0;
               pick_ok_in = 1'b0;
               count_in   = '0;
               done_in    = '0;
            end
         iou_pkg::ST_SCAN:
            if (!valid_ff[slot_ff]) begin
               if (!free_ok_ff) begin
                  free_ok_in = 1'b1;
                  free_in    = slot_ff;
               end
               if (!slot_end) slot_in = slot_ff + 1'b1;
            end
         iou_pkg::ST_TEST: begin
            if (uni_ff != '0 && mul_p > rhs_ff &&
                (!best_ok_ff || slot_id < best_id_ff)) begin
               best_ok_in = 1'b1;
               best_in    = slot_ff;
               best_id_in = slot_id;
            end
            if (!slot_end) slot_in = slot_ff + 1'b1;
         end
         iou_pkg::ST_DECIDE:
            // wait until the previous result item has left the register
            if (!ovalid_ff || rsp_tready) begin
               olast_in = 1'b1;
               if (best_ok_ff) begin
                  wr_match = 1'b1;
                  found_in[best_ff] = 1'b1;
                  odata_in = {life_mem[best_ff], reg_ff, best_id_ff, iou_pkg::KIND_MATCHED};
               end else if (free_ok_ff) begin
                  wr_new = 1'b1;
                  valid_in[free_ff] = 1'b1;
                  found_in[free_ff] = 1'b0;
                  next_id_in = next_id_ff + 32'd1;
                  odata_in = {init_life_ff, reg_ff, next_id_ff, iou_pkg::KIND_NEW};
               end else begin
                  odata_in = {4'd0, reg_ff, 32'd0, iou_pkg::KIND_DROPPED};
               end
            end
         iou_pkg::ST_AGE: begin
            if (valid_ff[slot_ff]) begin
               wr_age = 1'b1;
               if (found_ff[slot_ff]) aged_life = init_life_ff;
               else if (slot_life != 4'd0) aged_life = slot_life - 4'd1;
               found_in[slot_ff] = 1'b0;
               if (aged_life == 4'd0) valid_in[slot_ff] = 1'b0;
            end
            slot_in = slot_end ? '0 : slot_ff + 1'b1;
         end
         iou_pkg::ST_PICK: begin
            if (valid_ff[slot_ff] && !done_ff[slot_ff] &&
                (!pick_ok_ff || slot_id < pick_id_ff)) begin
               pick_ok_in = 1'b1;
               pick_in    = slot_ff;
               pick_id_in = slot_id;
            end
            slot_in = slot_end ? '0 : slot_ff + 1'b1;
         end
         iou_pkg::ST_EMIT:
            if (!ovalid_ff || rsp_tready) begin
               pick_ok_in = 1'b0;
               if (pick_ok_ff) begin
                  done_in[pick_ff] = 1'b1;
                  count_in  = count_ff + 1'b1;
                  ovalid_in = 1'b1;
                  odata_in  = {life_mem[pick_ff], rect_mem[pick_ff], pick_id_ff,
                               iou_pkg::KIND_REPORT};
                  olast_in  = report_last;
               end else if (count_ff == '0) begin
                  olast_in = 1'b1;
                  odata_in = {4'd0, {RB{1'b0}}, 32'd0, iou_pkg::KIND_EMPTY};
               end
            end
         iou_pkg::ST_OUT:
            if (!ovalid_ff || rsp_tready) ovalid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iou_pkg::ST_IDLE;
         valid_ff     <= '0;
         found_ff     <= '0;
         done_ff      <= '0;
         next_id_ff   <= '0;
         ovalid_ff    <= 1'b0;
         num_ff       <= 8'd2;
         den_ff       <= 8'd5;
         init_life_ff <= 4'd5;
         pick_ok_ff   <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         found_ff   <= found_in;
         done_ff    <= done_in;
         next_id_ff <= next_id_in;
         ovalid_ff  <= ovalid_in;
         pick_ok_ff <= pick_ok_in;
         count_ff   <= count_in;
         if (csr_we) begin
            case (csr_index)
               iou_pkg::CSR_NUMERATOR:   num_ff       <= csr_wdata;
               iou_pkg::CSR_DENOMINATOR: den_ff       <= csr_wdata;
               iou_pkg::CSR_INIT_LIFE:   init_life_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      reg_ff     <= reg_in;
      best_ok_ff <= best_ok_in;
      best_ff    <= best_in;
      best_id_ff <= best_id_in;
      free_ok_ff <= free_ok_in;
      free_ff    <= free_in;
      pick_ff    <= pick_in;
      pick_id_ff <= pick_id_in;
      olast_ff   <= olast_in;
      odata_ff   <= odata_in;
      case (state_ff)
         iou_pkg::ST_SCAN: inter_ff <= AB'(mul_p);
         iou_pkg::ST_MUL1: area_ff <= AB'(mul_p);
         iou_pkg::ST_MUL2: uni_ff <= area_ff + AB'(mul_p) - inter_ff;
         // union scaled by the numerator, compared against inter * den next
         iou_pkg::ST_MUL3: rhs_ff <= mul_p;
         default: ;
      endcase
      if (wr_match) rect_mem[best_ff] <= reg_ff;
      if (wr_new) begin
         id_mem[free_ff]   <= next_id_ff;
         rect_mem[free_ff] <= reg_ff;
         life_mem[free_ff] <= init_life_ff;
      end
      if (wr_age) life_mem[slot_ff] <= aged_life;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = OW'(odata_ff);

   logic unused_ok;
   assign unused_ok = ^{req_tdata[IW-1:RB+1]};

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid || rsp_tlast)
      else $error("request taken while a response run is open");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");
   a_next_id: assert property (@(posedge clock) disable iff (reset)
      next_id_ff != $past(next_id_ff) |-> $past(state_ff) == iou_pkg::ST_DECIDE)
      else $error("id counter moved outside track creation");

endmodule
`default_nettype wire
